// ===== rtl/core/rmbc_pkg.sv =====
// Package for the four-channel running mean bound check core.
// Widths, reset values, register indexes and the lane control struct.
// No dependencies.
`default_nettype none

package rmbc_pkg;

   localparam int NUM_CH      = 4;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;
   localparam int BOUND_WIDTH = 32;
   localparam int TOTAL_WIDTH = 34;
   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
   localparam int CMP_WIDTH   = (VALUE_WIDTH > BOUND_WIDTH) ? VALUE_WIDTH : BOUND_WIDTH;
   localparam int CSR_IDX_WIDTH = 2;

   localparam int REQ_DATA_WIDTH = ((NUM_CH * VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS       = NUM_CH * VALUE_WIDTH + TOTAL_WIDTH + 1;
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   // 0.001 and 0.01 in Q8.24, truncated
   localparam logic [BOUND_WIDTH-1:0] BOUND_LOW_RESET  = BOUND_WIDTH'(16777);
   localparam logic [BOUND_WIDTH-1:0] BOUND_HIGH_RESET = BOUND_WIDTH'(167772);

   localparam logic [CSR_IDX_WIDTH-1:0] REG_BOUND_A = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BOUND_B = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BOUND_C = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BOUND_D = 2'd3;

   typedef logic [NUM_CH-1:0][VALUE_WIDTH-1:0] mean_vec_type;
   typedef logic [NUM_CH-1:0][BOUND_WIDTH-1:0] bound_vec_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic commit;
   } lane_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/rmbc_lane.sv =====
// One channel lane: running mean register and a restoring divider that
// produces one quotient bit per cycle. Depends on rmbc_pkg.
`default_nettype none

module rmbc_lane (
   input  wire                            clock,
   input  wire                            reset,
   input  rmbc_pkg::lane_ctl_type         ctl,
   input  wire [rmbc_pkg::COUNT_WIDTH-1:0] count,
   input  wire [rmbc_pkg::VALUE_WIDTH-1:0] sample,
   output logic [rmbc_pkg::VALUE_WIDTH-1:0] mean
);

   localparam int VW = rmbc_pkg::VALUE_WIDTH;
   localparam int CW = rmbc_pkg::COUNT_WIDTH;

   logic [VW-1:0] mean_ff, mean_in;
   logic [VW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] den_ff, den_in;
   logic          neg_ff, neg_in;

   logic [CW:0]   rem_shift;
   logic [CW:0]   rem_sub;
   logic          fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[VW-1]};
      rem_sub   = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};

      mean_in = mean_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;

      if (ctl.load) begin
         neg_in = sample < mean_ff;
         quo_in = neg_in ? (mean_ff - sample) : (sample - mean_ff);
         rem_in = '0;
         den_in = count;
      end else if (ctl.shift) begin
         quo_in = {quo_ff[VW-2:0], fits};
         rem_in = fits ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
      end else if (ctl.commit) begin
         mean_in = neg_ff ? (mean_ff - quo_ff) : (mean_ff + quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
      end else begin
         mean_ff <= mean_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign mean = mean_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rmbc_merge.sv =====
// Merge stage: sums the four lane means and checks each against its bound,
// registering the total and the flag. Depends on rmbc_pkg.
`default_nettype none

module rmbc_merge (
   input  wire                                 clock,
   input  wire                                 capture,
   input  rmbc_pkg::mean_vec_type              means,
   input  rmbc_pkg::bound_vec_type             bounds,
   output logic [rmbc_pkg::TOTAL_WIDTH-1:0]    total,
   output logic                                in_bounds
);

   localparam int TW = rmbc_pkg::TOTAL_WIDTH;
   localparam int MW = rmbc_pkg::CMP_WIDTH;

   logic [TW-1:0] total_ff, total_in;
   logic          in_bounds_ff, in_bounds_in;

   always_comb begin
      total_in     = '0;
      in_bounds_in = 1'b1;
      for (int i = 0; i < rmbc_pkg::NUM_CH; i++) begin
         total_in = total_in + TW'(means[i]);
         if (MW'(means[i]) > MW'(bounds[i])) begin
            in_bounds_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         total_ff     <= total_in;
         in_bounds_ff <= in_bounds_in;
      end
   end

   assign total     = total_ff;
   assign in_bounds = in_bounds_ff;

endmodule

`default_nettype wire

// ===== rtl/core/four_channel_running_mean_bound_check_core.sv =====
// Four-channel running mean with bound check, top level.
// rsp_tvalid rises after the req transaction has gone through load, 32
// divider steps, commit, merge and the output register; no request is taken
// while one is still in flight. A stalled rsp holds off the next request
// only until its pending result moves into the output register.
// Synchronous active-high reset clears means, count and control, and loads the bounds with their reset values.
// Depends on rmbc_pkg, rmbc_lane, rmbc_merge.
`default_nettype none

module four_channel_running_mean_bound_check_core (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   // sample_a, sample_b, sample_c, sample_d
   input  wire [rmbc_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // mean_a, mean_b, mean_c, mean_d, mean_total, within_limits, zero pad
   output logic [rmbc_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   input  wire                                    csr_we,
   input  wire [rmbc_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  wire [rmbc_pkg::BOUND_WIDTH-1:0]        csr_wdata
);

   localparam int VW = rmbc_pkg::VALUE_WIDTH;
   localparam int CW = rmbc_pkg::COUNT_WIDTH;
   localparam int SW = rmbc_pkg::STEP_WIDTH;
   localparam int NC = rmbc_pkg::NUM_CH;
   localparam int TW = rmbc_pkg::TOTAL_WIDTH;
   localparam int PAD = rmbc_pkg::RSP_DATA_WIDTH - rmbc_pkg::RSP_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIV    = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam logic [1:0] ST_MERGE  = 2'd3;

   localparam logic [SW-1:0] STEP_LAST = SW'(VW - 1);

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in, count_next;
   logic          out_pend_ff, out_pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_accept, out_load;

   rmbc_pkg::bound_vec_type bound_ff;
   rmbc_pkg::mean_vec_type  means;
   rmbc_pkg::mean_vec_type  rsp_mean_ff;
   logic [TW-1:0]           rsp_total_ff;
   logic                    rsp_within_ff;
   logic [TW-1:0]           total;
   logic                    in_bounds;
   rmbc_pkg::lane_ctl_type  lane_ctl;

   assign req_tready = (state_ff == ST_IDLE) && !out_pend_ff;
   assign req_accept = req_tvalid && req_tready;
   assign count_next = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign out_load   = out_pend_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      count_in    = count_ff;
      out_pend_in = out_pend_ff;
      lane_ctl    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               lane_ctl.load = 1'b1;
               count_in      = count_next;
               step_in       = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            lane_ctl.shift = 1'b1;
            step_in        = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            lane_ctl.commit = 1'b1;
            state_in        = ST_MERGE;
         end
         ST_MERGE: begin
            out_pend_in = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_pend_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tvalid && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         out_pend_ff  <= out_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff[0] <= rmbc_pkg::BOUND_LOW_RESET;
         bound_ff[1] <= rmbc_pkg::BOUND_HIGH_RESET;
         bound_ff[2] <= rmbc_pkg::BOUND_HIGH_RESET;
         bound_ff[3] <= rmbc_pkg::BOUND_HIGH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rmbc_pkg::REG_BOUND_A: bound_ff[0] <= csr_wdata;
            rmbc_pkg::REG_BOUND_B: bound_ff[1] <= csr_wdata;
            rmbc_pkg::REG_BOUND_C: bound_ff[2] <= csr_wdata;
            rmbc_pkg::REG_BOUND_D: bound_ff[3] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // means stay put until the next load, which waits for out_pend to clear
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mean_ff   <= means;
         rsp_total_ff  <= total;
         rsp_within_ff <= in_bounds;
      end
   end

   for (genvar g = 0; g < NC; g++) begin : g_lane
      rmbc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .count  (count_in),
         .sample (req_tdata[g*VW +: VW]),
         .mean   (means[g])
      );
   end

   rmbc_merge u_merge (
      .clock     (clock),
      .capture   (lane_ctl.commit == 1'b0 && state_ff == ST_MERGE),
      .means     (means),
      .bounds    (bound_ff),
      .total     (total),
      .in_bounds (in_bounds)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD{1'b0}}, rsp_within_ff, rsp_total_ff, rsp_mean_ff};

`ifndef SYNTHESIS
   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_DIV) && (step_ff == '0))
      else $error("request transaction did not start the divider");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '1) |=> (count_ff == '1))
      else $error("sample count left saturation");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && !out_pend_ff)
      else $error("result load did not raise rsp_tvalid");

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      out_pend_ff |-> !req_tready)
      else $error("request taken while a result is pending");
`endif

endmodule

`default_nettype wire
